@@ sv/npsd_pkg.sv @@
// ----------------------------------------------------------------------------
// npsd_pkg: shared types and constants of the nearest point search
// Field widths, register indexes, the queue entry and the back-end states.
// ----------------------------------------------------------------------------
package npsd_pkg;

   localparam int COORD_W   = 24;           // signed Q15.8 coordinate
   localparam int DIFF_W    = 24;           // magnitude of a coordinate difference
   localparam int PROD_W    = 2 * DIFF_W;   // one squared difference
   localparam int SQ_W      = 50;           // squared distance
   localparam int ROOT_W    = 25;           // floor square root, Q.8
   localparam int INDEX_W   = 16;
   localparam int INDEX_MAX = 65535;
   localparam int CSR_IDX_W = 4;

   localparam int DEFAULT_MAX_POINTS = 65536;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int ROOT_STEPS  = ROOT_W;
   localparam int ROOT_STEP_W = $clog2(ROOT_STEPS);
   localparam int ROOT_REM_W  = ROOT_W + 3;

   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_U = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_V = CSR_IDX_W'(1);

   // One classified point on its way from front to back end
   typedef struct packed {
      logic [DIFF_W-1:0]  du;
      logic [DIFF_W-1:0]  dv;
      logic [INDEX_W-1:0] index;
      logic               sat;
      logic               last;
   } npsd_entry_type;

   // Hand-off of a finished set to the root unit
   typedef struct packed {
      logic               go;
      logic [SQ_W-1:0]    square;
      logic [INDEX_W-1:0] index;
      logic               sat;
   } npsd_start_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL_V,
      S_FIN
   } npsd_back_state_type;

endpackage

@@ sv/npsd_if.sv @@
// ----------------------------------------------------------------------------
// npsd_if: channel interfaces of the nearest point search
// Request, response and register-write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface npsd_req_if import npsd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_u;
   logic signed [COORD_W-1:0] point_v;
   logic                      is_last;

   modport source (output valid, point_u, point_v, is_last, input ready);
   modport sink   (input valid, point_u, point_v, is_last, output ready);
endinterface

interface npsd_rsp_if import npsd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ROOT_W-1:0]  min_distance;
   logic [INDEX_W-1:0] min_index;
   logic               index_saturated;

   modport source (output valid, min_distance, min_index, index_saturated, input ready);
   modport sink   (input valid, min_distance, min_index, index_saturated, output ready);
endinterface

interface npsd_csr_if import npsd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COORD_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/npsd_front.sv @@
// ----------------------------------------------------------------------------
// npsd_front: request intake and classification
// Holds the query point, forms coordinate difference magnitudes and assigns
// each point its position in the set, with saturation at the position cap.
// ----------------------------------------------------------------------------
module npsd_front import npsd_pkg::*; #(
   parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
   input  logic           clock,
   input  logic           reset,
   npsd_req_if.sink       req,
   npsd_csr_if.sink       csr,
   output logic           push_valid,
   input  logic           push_ready,
   output npsd_entry_type push_data
);

   localparam int CAP = (MAX_POINTS - 1 > INDEX_MAX) ? INDEX_MAX : MAX_POINTS - 1;
   localparam logic [INDEX_W-1:0] CAP_VAL = INDEX_W'(CAP);

   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      if (d[COORD_W]) begin
         d = -d;
      end
      return d[DIFF_W-1:0];
   endfunction

   logic signed [COORD_W-1:0] query_u_ff, query_u_in;
   logic signed [COORD_W-1:0] query_v_ff, query_v_in;
   logic [INDEX_W-1:0]        count_ff, count_in;
   logic                      cap_taken_ff, cap_taken_in;
   logic                      ovf_ff, ovf_in;
   logic                      accept;
   logic [INDEX_W-1:0]        pos;
   logic                      sat_now;

   assign csr.ready  = 1'b1;
   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign accept     = req.valid && push_ready;

   always_comb begin
      query_u_in = query_u_ff;
      query_v_in = query_v_ff;
      if (csr.valid) begin
         if (csr.index == CSR_QUERY_U) begin
            query_u_in = csr.data;
         end
         if (csr.index == CSR_QUERY_V) begin
            query_v_in = csr.data;
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      cap_taken_in = cap_taken_ff;
      ovf_in       = ovf_ff;
      sat_now      = ovf_ff;
      pos          = count_ff;
      if (count_ff >= CAP_VAL) begin
         pos     = CAP_VAL;
         sat_now = ovf_ff || cap_taken_ff;
      end
      if (accept) begin
         if (req.is_last) begin
            // clear for the next set
            count_in     = '0;
            cap_taken_in = 1'b0;
            ovf_in       = 1'b0;
         end else if (count_ff >= CAP_VAL) begin
            cap_taken_in = 1'b1;
            ovf_in       = sat_now;
         end else begin
            count_in = count_ff + INDEX_W'(1);
         end
      end
   end

   always_comb begin
      push_data.du    = abs_diff(req.point_u, query_u_ff);
      push_data.dv    = abs_diff(req.point_v, query_v_ff);
      push_data.index = pos;
      push_data.sat   = sat_now;
      push_data.last  = req.is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_u_ff   <= '0;
         query_v_ff   <= '0;
         count_ff     <= '0;
         cap_taken_ff <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         query_u_ff   <= query_u_in;
         query_v_ff   <= query_v_in;
         count_ff     <= count_in;
         cap_taken_ff <= cap_taken_in;
         ovf_ff       <= ovf_in;
      end
   end

endmodule

@@ sv/npsd_queue.sv @@
// ----------------------------------------------------------------------------
// npsd_queue: short FIFO between front and back end
// Decouples request intake from the multiply and compare work.
// ----------------------------------------------------------------------------
module npsd_queue import npsd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  npsd_entry_type push_data,
   output logic           pop_valid,
   input  logic           pop_ready,
   output npsd_entry_type pop_data
);

   npsd_entry_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                       push;
   logic                       pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
      return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/npsd_back.sv @@
// ----------------------------------------------------------------------------
// npsd_back: squared distance and running minimum
// One 24x24 multiplier squares du, then dv; the sum is compared against the
// best of the set. The last point of a set hands the best to the root unit.
// ----------------------------------------------------------------------------
module npsd_back import npsd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   output logic           q_ready,
   input  npsd_entry_type q_data,
   input  logic           root_ready,
   output npsd_start_type start
);

   npsd_back_state_type state_ff, state_in;
   logic [DIFF_W-1:0]   dv_ff, dv_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic                sat_ff, sat_in;
   logic                last_ff, last_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [SQ_W-1:0]     best_ff, best_in;
   logic [INDEX_W-1:0]  best_index_ff, best_index_in;
   logic                pop;
   logic                finish;
   logic [DIFF_W-1:0]   mul_a;
   logic [SQ_W-1:0]     sum;
   logic                better;

   assign q_ready = pop;
   assign sum     = {{(SQ_W - PROD_W){1'b0}}, acc_ff} + {{(SQ_W - PROD_W){1'b0}}, prod_ff};
   assign better  = sum < best_ff;

   always_comb begin
      state_in      = state_ff;
      pop           = 1'b0;
      finish        = 1'b0;
      mul_a         = q_data.du;
      dv_in         = dv_ff;
      index_in      = index_ff;
      sat_in        = sat_ff;
      last_in       = last_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      best_in       = best_ff;
      best_index_in = best_index_ff;
      start.go      = 1'b0;
      start.square  = better ? sum : best_ff;
      start.index   = better ? index_ff : best_index_ff;
      start.sat     = sat_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               state_in = S_MUL_V;
            end
         end
         S_MUL_V: begin
            mul_a    = dv_ff;
            acc_in   = prod_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold the last point until the root unit is free
            if (!last_ff || root_ready) begin
               finish = 1'b1;
               if (q_valid) begin
                  pop      = 1'b1;
                  state_in = S_MUL_V;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (pop || state_ff == S_MUL_V) begin
         prod_in = PROD_W'(mul_a) * PROD_W'(mul_a);
      end

      if (pop) begin
         dv_in    = q_data.dv;
         index_in = q_data.index;
         sat_in   = q_data.sat;
         last_in  = q_data.last;
      end

      if (finish) begin
         if (last_ff) begin
            start.go      = 1'b1;
            best_in       = '1;
            best_index_in = '0;
         end else if (better) begin
            best_in       = sum;
            best_index_in = index_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      dv_ff    <= dv_in;
      index_ff <= index_in;
      sat_ff   <= sat_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_ff       <= 1'b0;
         best_ff       <= '1;
         best_index_ff <= '0;
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         best_ff       <= best_in;
         best_index_ff <= best_index_in;
      end
   end

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start.go |-> root_ready)
      else $error("set handed to busy root unit");

   a_clear_after_set: assert property (@(posedge clock) disable iff (reset)
      (finish && last_ff) |=> (best_ff == '1 && best_index_ff == '0))
      else $error("best not cleared after last point");

   a_second_square: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL_V |=> state_ff == S_FIN)
      else $error("dv square not followed by compare");

endmodule

@@ sv/npsd_root.sv @@
// ----------------------------------------------------------------------------
// npsd_root: floor square root and response register
// Digit-by-digit root, two radicand bits per cycle, then hold the response.
// ----------------------------------------------------------------------------
module npsd_root import npsd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  npsd_start_type start,
   output logic           root_ready,
   npsd_rsp_if.source     rsp
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [ROOT_STEP_W-1:0] step_ff, step_in;
   logic [SQ_W-1:0]        x_ff, x_in;
   logic [ROOT_REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0]      root_ff, root_in;
   logic [INDEX_W-1:0]     index_ff, index_in;
   logic                   sat_ff, sat_in;
   logic [ROOT_REM_W-1:0]  rem_sh;
   logic [ROOT_REM_W-1:0]  trial;

   assign root_ready          = !busy_ff && !done_ff;
   assign rsp.valid           = done_ff;
   assign rsp.min_distance    = root_ff;
   assign rsp.min_index       = index_ff;
   assign rsp.index_saturated = sat_ff;

   assign rem_sh = {rem_ff[ROOT_REM_W-3:0], x_ff[SQ_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      step_in  = step_ff;
      x_in     = x_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      index_in = index_ff;
      sat_in   = sat_ff;
      if (start.go) begin
         busy_in  = 1'b1;
         step_in  = ROOT_STEP_W'(ROOT_STEPS - 1);
         x_in     = start.square;
         rem_in   = '0;
         root_in  = '0;
         index_in = start.index;
         sat_in   = start.sat;
      end else if (busy_ff) begin
         x_in = {x_ff[SQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - ROOT_STEP_W'(1);
         end
      end else if (done_ff && rsp.ready) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      x_ff     <= x_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      index_ff <= index_in;
      sat_ff   <= sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   a_busy_or_done: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("root unit busy while holding a response");

   a_done_after_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff == '0) |=> (done_ff && !busy_ff))
      else $error("root did not finish after last step");

endmodule

@@ sv/nearest_point_search_2d_unit.sv @@
// Throughput: points share the one 24x24 multiplier that squares du, then dv; the next point
//   leaves the queue while the one before is compared. With the back end idle, a last point
//   is written to the queue, leaves it while du is squared, has dv squared, is compared and
//   handed off, then the digit-by-digit root runs its 25 steps (one bit a cycle) to the response.
// The root unit holds one response; a following set streams on and waits at its last point.
// Reset is synchronous, active high: query point zero, best distance all ones, queue empty.
// ----------------------------------------------------------------------------
// nearest_point_search_2d_unit: nearest point to a query in the plane
// Streams measured points, keeps the smallest squared Euclidean distance and
// its position, and reports the floor square root of that distance per set.
// ----------------------------------------------------------------------------
module nearest_point_search_2d_unit import npsd_pkg::*; #(
   parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
   input  logic        clock,
   input  logic        reset,
   npsd_req_if.sink    req_bus,
   npsd_rsp_if.source  rsp_bus,
   npsd_csr_if.sink    csr_bus
);

   // front end to queue
   logic           push_valid;
   logic           push_ready;
   npsd_entry_type push_data;

   // queue to back end
   logic           q_valid;
   logic           q_ready;
   npsd_entry_type q_data;

   // back end to root unit
   logic           root_ready;
   npsd_start_type start;

   // Front: take requests and register writes, classify each point
   npsd_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .csr        (csr_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Queue: let intake run ahead while the multiplier works
   npsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   // Back: square, sum and track the minimum
   npsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_data     (q_data),
      .root_ready (root_ready),
      .start      (start)
   );

   // Root: floor square root, then hold the response until taken
   npsd_root u_root (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .root_ready (root_ready),
      .rsp        (rsp_bus)
   );

endmodule
